[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

[rtl/bmv_pkg.sv]
// ----------------------------------------------------------------------------
// bmv_pkg
// shared sizes, register codes and state type of the box mean filter
// ----------------------------------------------------------------------------
package bmv_pkg;

    // build-time limits
    localparam int MAX_MAP_WIDTH  = 256;
    localparam int MAX_WIN_HEIGHT = 64;
    localparam int MAX_WIN_WIDTH  = 64;
    localparam int MAP_H_LIM      = 256;

    // limits as seen through the register widths
    localparam int MAP_W_LIM = (MAX_MAP_WIDTH < 511) ? MAX_MAP_WIDTH : 511;
    localparam int WIN_W_LIM = (MAX_WIN_WIDTH < 127) ? MAX_WIN_WIDTH : 127;
    localparam int WIN_H_LIM = (MAX_WIN_HEIGHT < 127) ? MAX_WIN_HEIGHT : 127;

    localparam int COL_W   = $clog2(MAP_W_LIM);
    localparam int ROW_W   = $clog2(MAP_H_LIM);
    localparam int RING_AW = $clog2(WIN_W_LIM);
    localparam int SLOT_W  = $clog2(WIN_H_LIM);

    localparam int STORE_AW    = SLOT_W + COL_W;
    localparam int STORE_DEPTH = 2 ** STORE_AW;

    // column sums in the lower half, recent column ring in the upper half
    localparam int SUM_IDX_W = (COL_W > RING_AW) ? COL_W : RING_AW;
    localparam int SUM_AW    = SUM_IDX_W + 1;
    localparam int SUM_DEPTH = 2 ** SUM_AW;

    // datapath widths
    localparam int PIX_W  = 16;
    localparam int CS_W   = 22;
    localparam int SUM_W  = 28;
    localparam int QUO_W  = 16;
    localparam int AREA_W = 14;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 3'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_ROW,
        S_DIV,
        S_DONE
    } t_state;

endpackage

[rtl/bmv_ram.sv]
// ----------------------------------------------------------------------------
// bmv_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bmv_div.sv]
// ----------------------------------------------------------------------------
// bmv_div
// radix-2 restoring divider, window sum by window area, one bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmv_div
    import bmv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [AREA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quotient
);

    localparam int REM_W = AREA_W + 1;
    localparam int CNT_W = $clog2(QUO_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [AREA_W-1:0] r_divisor;

    logic [REM_W-1:0] trial;
    logic             fits;

    // quotient always fits in QUO_W bits, so the upper dividend bits start
    // out below the divisor
    always_comb begin
        trial = {r_rem[REM_W-2:0], r_quo[QUO_W-1]};
        fits  = trial >= {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= REM_W'(i_dividend[SUM_W-1:QUO_W]);
            r_quo     <= i_dividend[QUO_W-1:0];
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_divisor}) : trial;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n, i_start && r_busy)
    `ASSERT_CLK(a_start_then_busy, i_clk, i_rst_n, i_start |=> (r_busy && !r_done))
    `ASSERT_CLK(a_done_ends_busy, i_clk, i_rst_n, r_done |-> ($fell(r_busy) && !i_start))

endmodule

[rtl/box_mean_valid_windows.sv]
// ----------------------------------------------------------------------------
// box_mean_valid_windows
// streaming box-filter mean over every window lying inside the map
// ----------------------------------------------------------------------------
// Takes one Q0.16 likelihood beat at a time in raster order and returns the
// floored mean of every win_width x win_height window lying wholly inside the
// map, in row-major order, with frame_last on the window that ends at the
// map's last pixel. A pixel that closes no window passes through an accept
// with memory reads, a column-sum update and a row-sum update. A pixel that
// closes a window passes through the same steps, then the bit-serial divider
// works out the sum/area quotient and a done state hands it to the output
// register. The output register decouples the result side, so the next pixel
// is taken while a mean waits; the block holds off input while it works on a
// pixel and while a new mean is ready and the previous one is still not taken.
// Column sums and the ring of recent column sums share one ram, the recent
// rows sit in a second one; neither needs clearing after reset. A write to
// one of the four size registers restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_mean_valid_windows
    import bmv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_likelihood,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [QUO_W-1:0]      o_window_mean,
    output logic                  o_frame_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [8:0] r_map_width, r_map_height;
    logic [6:0] r_win_width, r_win_height;
    logic [8:0] w_eff, h_eff;
    logic [6:0] ww_eff, wh_eff;
    logic       cfg_hit;

    // raster position of the next pixel
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic [9:0]       c_inc;
    logic [8:0]       r_inc;
    logic [8:0]       old_row;
    logic [9:0]       ring_back;

    // per-beat context
    logic [PIX_W-1:0]   r_px;
    logic [COL_W-1:0]   r_c;
    logic [SLOT_W-1:0]  r_slot_new;
    logic               r_row_zero, r_r_ge_wh, r_c_zero, r_c_ge_ww;
    logic [RING_AW-1:0] r_ring_rd;
    logic               r_emit, r_last;
    logic [AREA_W-1:0]  r_area;

    // sums
    logic [CS_W-1:0]  r_cs, n_cs;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CS_W-1:0]  cs_drop, ring_drop;

    // memories
    logic [PIX_W-1:0]  store_q;
    logic              store_we;
    logic [CS_W-1:0]   sum_q, sum_wdata;
    logic              sum_we, sum_re;
    logic [SUM_AW-1:0] sum_waddr, sum_raddr;

    // control
    logic in_accept, div_start, div_done, out_load;
    logic [QUO_W-1:0] div_quo;

    // output register
    logic             r_out_valid;
    logic [QUO_W-1:0] r_out_mean;
    logic             r_out_last;

    always_comb begin
        w_eff  = (r_map_width == 9'd0) ? 9'd1 :
                 (r_map_width > 9'(MAP_W_LIM)) ? 9'(MAP_W_LIM) : r_map_width;
        h_eff  = (r_map_height == 9'd0) ? 9'd1 :
                 (r_map_height > 9'(MAP_H_LIM)) ? 9'(MAP_H_LIM) : r_map_height;
        ww_eff = (r_win_width == 7'd0) ? 7'd1 :
                 (r_win_width > 7'(WIN_W_LIM)) ? 7'(WIN_W_LIM) : r_win_width;
        wh_eff = (r_win_height == 7'd0) ? 7'd1 :
                 (r_win_height > 7'(WIN_H_LIM)) ? 7'(WIN_H_LIM) : r_win_height;
    end

    // position wraps when a smaller map was configured
    always_comb begin
        c_cur     = (10'(r_col) >= 10'(w_eff)) ? '0 : r_col;
        r_cur     = (9'(r_row) >= h_eff) ? '0 : r_row;
        c_inc     = 10'(c_cur) + 10'd1;
        r_inc     = 9'(r_cur) + 9'd1;
        old_row   = 9'(r_cur) - 9'(wh_eff);
        ring_back = 10'(c_cur) - 10'(ww_eff);
    end

    always_comb begin
        case (i_cfg_index)
            CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_WIN_WIDTH, CFG_WIN_HEIGHT: begin
                cfg_hit = i_cfg_we;
            end
            default: begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 9'd256;
            r_map_height <= 9'd256;
            r_win_width  <= 7'd8;
            r_win_height <= 7'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                CFG_WIN_WIDTH:  r_win_width  <= i_cfg_data[6:0];
                CFG_WIN_HEIGHT: r_win_height <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (c_inc >= 10'(w_eff)) begin
                r_col <= '0;
                r_row <= (r_inc >= h_eff) ? '0 : r_cur + 1'b1;
            end else begin
                r_col <= c_cur + 1'b1;
                r_row <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_px       <= i_likelihood;
            r_c        <= c_cur;
            r_slot_new <= r_cur[SLOT_W-1:0];
            r_row_zero <= (r_cur == '0);
            r_r_ge_wh  <= (9'(r_cur) >= 9'(wh_eff));
            r_c_zero   <= (c_cur == '0);
            r_c_ge_ww  <= (10'(c_cur) >= 10'(ww_eff));
            r_ring_rd  <= ring_back[RING_AW-1:0];
            r_emit     <= (r_inc >= 9'(wh_eff)) && (c_inc >= 10'(ww_eff));
            r_last     <= (r_inc == h_eff) && (c_inc == 10'(w_eff));
            r_area     <= AREA_W'(ww_eff) * AREA_W'(wh_eff);
        end
    end

    // column sum: add the new pixel, drop the row leaving the window
    always_comb begin
        cs_drop = r_r_ge_wh ? CS_W'(store_q) : '0;
        n_cs    = r_row_zero ? CS_W'(r_px) : (sum_q + CS_W'(r_px) - cs_drop);
    end

    // row sum: sum_q now holds the ring entry ww columns back
    always_comb begin
        ring_drop = r_c_ge_ww ? sum_q : '0;
        n_sum     = r_c_zero ? SUM_W'(r_cs) :
                    (r_sum + SUM_W'(r_cs) - SUM_W'(ring_drop));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COL) begin
            r_cs <= n_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_state == S_ROW) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_COL;
                end
            end
            S_COL: begin
                n_state = S_ROW;
            end
            S_ROW: begin
                n_state = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_accept = 1'b0;
        store_we  = 1'b0;
        sum_we    = 1'b0;
        sum_re    = 1'b0;
        sum_waddr = {1'b0, SUM_IDX_W'(r_c)};
        sum_wdata = n_cs;
        sum_raddr = {1'b0, SUM_IDX_W'(c_cur)};
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_accept = i_in_valid;
                sum_re    = i_in_valid;
            end
            S_COL: begin
                store_we  = 1'b1;
                sum_we    = 1'b1;
                sum_re    = 1'b1;
                sum_raddr = {1'b1, SUM_IDX_W'(r_ring_rd)};
            end
            S_ROW: begin
                sum_we    = 1'b1;
                sum_waddr = {1'b1, SUM_IDX_W'(RING_AW'(r_c))};
                sum_wdata = r_cs;
                div_start = r_emit;
            end
            S_DONE: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    bmv_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr ({r_slot_new, r_c}),
        .i_wdata (r_px),
        .i_re    (in_accept),
        .i_raddr ({old_row[SLOT_W-1:0], c_cur}),
        .o_rdata (store_q)
    );

    bmv_ram #(
        .WIDTH (CS_W),
        .DEPTH (SUM_DEPTH)
    ) u_sum_mem (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_q)
    );

    bmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_area),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mean <= div_quo;
            r_out_last <= r_last;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_window_mean = r_out_mean;
    assign o_frame_last  = r_out_last;

    `ASSERT_CLK(a_accept_to_col, i_clk, i_rst_n, in_accept |=> (r_state == S_COL))
    `ASSERT_NEVER(a_done_outside_div, i_clk, i_rst_n, div_done && (r_state != S_DIV))
    `ASSERT_CLK(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == S_DONE))

endmodule

[test/window_mean_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_mean_check
// watches the pixel, result and register ports of the box mean filter, keeps
// its own line store, column sums and row sum, and compares every result beat
// against the oldest predicted window mean
// ----------------------------------------------------------------------------
module window_mean_check
    import bmv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [PIX_W-1:0]      i_likelihood,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [QUO_W-1:0]      i_window_mean,
    input  logic                  i_frame_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int WIN_REG_W = 7;

    typedef struct packed {
        logic [QUO_W-1:0] mean;
        logic             last;
    } t_window_mean;

    logic [CFG_DATA_W-1:0] map_w_reg;
    logic [CFG_DATA_W-1:0] map_h_reg;
    logic [WIN_REG_W-1:0]  win_w_reg;
    logic [WIN_REG_W-1:0]  win_h_reg;

    logic [PIX_W-1:0] row_lines [MAX_WIN_HEIGHT * MAX_MAP_WIDTH];
    logic [CS_W-1:0]  col_sums [MAX_MAP_WIDTH];
    logic [CS_W-1:0]  col_ring [MAX_WIN_WIDTH];
    logic [SUM_W-1:0] row_sum;
    int               col_pos;
    int               row_pos;

    t_window_mean expected_means [$];

    // a size of zero acts as one, oversized values saturate
    function automatic int clamp_dim(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MAP_WIDTH:  map_w_reg = val;
            CFG_MAP_HEIGHT: map_h_reg = val;
            CFG_WIN_WIDTH:  win_w_reg = val[WIN_REG_W-1:0];
            CFG_WIN_HEIGHT: win_h_reg = val[WIN_REG_W-1:0];
            default: ;
        endcase
        if (idx <= CFG_WIN_HEIGHT) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    task automatic predict_mean(input logic [PIX_W-1:0] px);
        int cols, rows, win_w, win_h, c, r;
        logic [CS_W-1:0] cs;
        t_window_mean m;
        cols  = clamp_dim(map_w_reg, MAX_MAP_WIDTH);
        rows  = clamp_dim(map_h_reg, MAP_H_LIM);
        win_w = clamp_dim(win_w_reg, MAX_WIN_WIDTH);
        win_h = clamp_dim(win_h_reg, MAX_WIN_HEIGHT);
        c = (col_pos >= cols) ? 0 : col_pos;
        r = (row_pos >= rows) ? 0 : row_pos;

        // column sum over the last win_h rows, row 0 reloads it
        if (r == 0) begin
            cs = CS_W'(px);
        end else begin
            cs = col_sums[c] + CS_W'(px);
            if (r >= win_h)
                cs = cs - CS_W'(row_lines[((r - win_h) % MAX_WIN_HEIGHT) * MAX_MAP_WIDTH + c]);
        end
        col_sums[c] = cs;
        row_lines[(r % MAX_WIN_HEIGHT) * MAX_MAP_WIDTH + c] = px;

        // running sum of the last win_w column sums, column 0 restarts it
        if (c == 0) begin
            row_sum = SUM_W'(cs);
        end else begin
            row_sum = row_sum + SUM_W'(cs);
            if (c >= win_w)
                row_sum = row_sum - SUM_W'(col_ring[(c - win_w) % MAX_WIN_WIDTH]);
        end
        col_ring[c % MAX_WIN_WIDTH] = cs;

        if (r + 1 >= win_h && c + 1 >= win_w) begin
            m.mean = QUO_W'(int'(row_sum) / (win_w * win_h));
            m.last = (r == rows - 1) && (c == cols - 1);
            expected_means.push_back(m);
        end

        if (c + 1 >= cols) begin
            col_pos = 0;
            row_pos = (r + 1 >= rows) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin
        t_window_mean want;
        if (!i_rst_n) begin
            map_w_reg = CFG_DATA_W'(256);
            map_h_reg = CFG_DATA_W'(256);
            win_w_reg = WIN_REG_W'(8);
            win_h_reg = WIN_REG_W'(8);
            foreach (col_sums[i]) col_sums[i] = '0;
            foreach (col_ring[i]) col_ring[i] = '0;
            row_sum = '0;
            col_pos = 0;
            row_pos = 0;
            expected_means.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_means.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result beat with none expected: mean %h frame_last %b",
                             $time, i_window_mean, i_frame_last);
                end else begin
                    want = expected_means.pop_front();
                    if (i_window_mean !== want.mean || i_frame_last !== want.last) begin
                        o_fail_count++;
                        $display("%0t: expected mean %h frame_last %b, got mean %h frame_last %b",
                                 $time, want.mean, want.last, i_window_mean, i_frame_last);
                    end
                end
            end
            if (i_cfg_we)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                predict_mean(i_likelihood);
        end
        o_pending = expected_means.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives pixel beats and register writes into the box mean filter under
// changing map and window sizes and idling patterns; the checker beside the
// block predicts every window mean and counts mismatches
// ----------------------------------------------------------------------------
module testbench;
    import bmv_pkg::*;

    localparam int PERIOD        = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 340;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int WIN_REG_W     = 7;
    localparam int MAP_CODE_MAX  = (1 << CFG_DATA_W) - 1;
    localparam int WIN_CODE_MAX  = (1 << WIN_REG_W) - 1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      likelihood  = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [QUO_W-1:0]      window_mean;
    logic                  frame_last;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int pending;
    int fail_count;
    int sent;
    int hold_asked;
    int hold_served;
    int tx_idle_pct;
    int rx_stall_pct;

    always #(PERIOD / 2) clk = ~clk;

    box_mean_valid_windows i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_likelihood  (likelihood),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_window_mean (window_mean),
        .o_frame_last  (frame_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    window_mean_check u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_likelihood  (likelihood),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_window_mean (window_mean),
        .i_frame_last  (frame_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // result side: random stalls, or a long hold-off when one is asked for
    initial begin
        forever begin
            @(negedge clk);
            if (hold_asked > hold_served) begin
                hold_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SENDER:   begin tx_idle_pct = 63; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
            IDLE_BOTH:     begin tx_idle_pct = 28; rx_stall_pct = 28; end
            default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        likelihood <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // drop valid, wait for every expected mean, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_sizes(input logic [CFG_DATA_W-1:0] mw, input logic [CFG_DATA_W-1:0] mh,
                               input logic [CFG_DATA_W-1:0] ww, input logic [CFG_DATA_W-1:0] wh);
        write_reg(CFG_MAP_WIDTH, mw);
        write_reg(CFG_MAP_HEIGHT, mh);
        write_reg(CFG_WIN_WIDTH, ww);
        write_reg(CFG_WIN_HEIGHT, wh);
    endtask

    task automatic write_bad_index();
        write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_WIN_HEIGHT + 1)),
                  CFG_DATA_W'($urandom));
    endtask

    // register code for a size: 1 may go as 0, the limit as itself or any
    // oversized value, window codes carry junk above their 7 bits
    function automatic logic [CFG_DATA_W-1:0] size_code(int n, int lim, int code_max);
        logic [CFG_DATA_W-1:0] code;
        code = CFG_DATA_W'(n);
        if (n == 1 && $urandom_range(2) == 0)
            code = '0;
        else if (n == lim)
            code = CFG_DATA_W'($urandom_range(code_max, lim));
        if (code_max < MAP_CODE_MAX)
            code[CFG_DATA_W-1:WIN_REG_W] = (CFG_DATA_W - WIN_REG_W)'($urandom_range(3));
        return code;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel(bit hot);
        if (hot && $urandom_range(3) != 0) return '1;
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    initial begin
        int phase, sel, mw, mh, ww, wh, count, random_end;
        bit hot;
        set_idling(IDLE_NONE);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sizes: 256x256 map, 8x8 window, nothing closes a window yet
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h5555);
        settle();

        // 1x1 window echoes every pixel; a bad register index must not restart
        set_idling(IDLE_BOTH);
        write_sizes(9'd3, 9'd2, 9'd1, 9'd1);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        settle();
        write_bad_index();
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);
        send_pixel(16'h8001);
        send_pixel(16'h7FFE);
        settle();

        // zero sizes act as one, window codes masked to their width
        set_idling(IDLE_SENDER);
        write_sizes(9'd0, 9'd0, 9'h080, 9'h100);
        send_pixel(16'hFFFF);
        send_pixel(16'h1234);
        settle();

        // window wider than the map gives no result
        set_idling(IDLE_RECEIVER);
        write_sizes(9'd2, 9'd2, 9'd3, 9'd2);
        repeat (4) send_pixel(16'hFFFF);
        settle();

        // window covers the whole map, two frames back to back
        set_idling(IDLE_NONE);
        write_sizes(9'd2, 9'd2, 9'd2, 9'd2);
        repeat (4) send_pixel(16'hFFFF);
        repeat (3) send_pixel(16'hFFFF);
        send_pixel(16'hFFFE);
        settle();

        // long hold-off on the result side while pixels keep coming
        write_sizes(9'd8, 9'd4, 9'd1, 9'd1);
        hold_asked++;
        repeat (32) send_pixel(rand_pixel(1'b0));
        settle();

        random_end = sent + RANDOM_ITEMS;
        phase = 0;
        while (sent < random_end) begin
            set_idling(t_idling'(phase % 4));
            hot = 1'b0;
            sel = (phase < 2) ? phase : $urandom_range(11);
            case (sel)
                0: begin
                    // widest map, one row of windows
                    mw = MAX_MAP_WIDTH;
                    mh = $urandom_range(2, 1);
                    ww = $urandom_range(1) ? MAX_WIN_WIDTH : $urandom_range(MAX_WIN_WIDTH, 1);
                    wh = 1;
                    count = $urandom_range(90, 70);
                    hot = 1'b1;
                end
                1: begin
                    // tallest map and window, one column
                    mw = 1;
                    mh = MAP_H_LIM;
                    ww = 1;
                    wh = MAX_WIN_HEIGHT;
                    count = $urandom_range(80, 64);
                    hot = 1'b1;
                end
                2: begin
                    mw = $urandom_range(4, 1);
                    mh = $urandom_range(4, 1);
                    if ($urandom_range(1)) begin
                        ww = mw + $urandom_range(3, 1);
                        wh = $urandom_range(mh, 1);
                    end else begin
                        ww = $urandom_range(mw, 1);
                        wh = mh + $urandom_range(3, 1);
                    end
                    count = mw * mh * $urandom_range(2, 1);
                end
                default: begin
                    mw = $urandom_range(10, 1);
                    mh = $urandom_range(8, 1);
                    ww = $urandom_range(mw, 1);
                    wh = $urandom_range(mh, 1);
                    count = mw * mh * $urandom_range(2, 1);
                    // frame cut short, the next write restarts it
                    if ($urandom_range(4) == 0)
                        count = $urandom_range(count, 1);
                end
            endcase
            write_sizes(size_code(mw, MAX_MAP_WIDTH, MAP_CODE_MAX),
                        size_code(mh, MAP_H_LIM, MAP_CODE_MAX),
                        size_code(ww, MAX_WIN_WIDTH, WIN_CODE_MAX),
                        size_code(wh, MAX_WIN_HEIGHT, WIN_CODE_MAX));
            if ($urandom_range(4) == 0)
                write_bad_index();
            repeat (count) send_pixel(rand_pixel(hot));
            settle();
            phase++;
        end

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bmv_pkg.sv
rtl/bmv_ram.sv
rtl/bmv_div.sv
rtl/box_mean_valid_windows.sv
test/window_mean_check.sv
test/testbench.sv
